FILE: hdl/rmst_pkg.sv
package rmst_pkg;

   localparam int LEAVES  = 1024;
   localparam int LEAF_W  = $clog2(LEAVES);
   localparam int NODE_W  = LEAF_W + 1;
   localparam int DEPTH   = 2 * LEAVES;
   localparam int IDX_W   = 10;
   localparam int VAL_W   = 31;

   localparam logic [VAL_W-1:0] EMPTY_VAL = {VAL_W{1'b1}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [VAL_W-1:0]  value_type;

   typedef struct packed {
      logic      en;
      node_type  addr;
      value_type data;
   } wr_port_type;

endpackage

FILE: hdl/rmst_tree_ram.sv
module rmst_tree_ram (
   input  logic                     clock,
   input  rmst_pkg::wr_port_type    wr,
   input  rmst_pkg::node_type       rd_a_addr,
   input  rmst_pkg::node_type       rd_b_addr,
   output rmst_pkg::value_type      rd_a_data,
   output rmst_pkg::value_type      rd_b_data
);

   rmst_pkg::value_type mem [rmst_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

FILE: hdl/range_min_segment_tree.sv
// Range-minimum segment tree with point writes, held in one 2*LEAVES-entry memory
// (one write port, two registered read ports). After reset the block sweeps
// every node to empty with busy high. An item is accepted when start is high
// and busy is low. A write first writes the leaf, then climbs a level at a time,
// reading the sibling and writing the parent up to the root, paced by the
// registered memory read. A query climbs at most LEAF_W-1 levels: it first reads
// the two boundary leaves, then at each level reads both boundary siblings.
// The result appears on rsp_minimum with rsp_strobe high for exactly one cycle,
// in the same cycle that busy drops; the receiver cannot stall it and must take
// it then. Writes return no result.
module range_min_segment_tree (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [rmst_pkg::IDX_W-1:0]  req_leaf_index,
   input  logic [rmst_pkg::IDX_W-1:0]  req_range_high,
   input  logic [rmst_pkg::VAL_W-1:0]  req_value,
   output logic                        rsp_strobe,
   output logic [rmst_pkg::VAL_W-1:0]  rsp_minimum
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_WLEAF  = 6'b000100,
      S_WUP    = 6'b001000,
      S_QSTART = 6'b010000,
      S_QWALK  = 6'b100000
   } state_type;

   localparam rmst_pkg::node_type NODE_ONE = rmst_pkg::node_type'(1);
   localparam rmst_pkg::node_type NODE_MAX = rmst_pkg::node_type'(rmst_pkg::DEPTH - 1);

   state_type           state_ff, state_in;
   rmst_pkg::node_type  clr_ff, clr_in;
   rmst_pkg::node_type  node_ff, node_in;
   rmst_pkg::node_type  rnode_ff, rnode_in;
   rmst_pkg::value_type cur_ff, cur_in;
   rmst_pkg::value_type mr_ff, mr_in;
   logic                fl_ff, fl_in;
   logic                fr_ff, fr_in;
   logic                first_ff, first_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rmst_pkg::value_type rsp_min_ff, rsp_min_in;

   rmst_pkg::wr_port_type wr;
   rmst_pkg::node_type    rd_a_addr, rd_b_addr;
   rmst_pkg::value_type   rd_a_data, rd_b_data;

   logic [rmst_pkg::LEAF_W-1:0] req_lo, req_hi;
   rmst_pkg::value_type         par_val, ml_nx, mr_nx;
   rmst_pkg::node_type          span;

   rmst_tree_ram u_ram (
      .clock     (clock),
      .wr        (wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      req_lo = req_leaf_index[rmst_pkg::LEAF_W-1:0];
      req_hi = req_range_high[rmst_pkg::LEAF_W-1:0];

      par_val = (rd_a_data < cur_ff) ? rd_a_data : cur_ff;

      // fold sibling values picked up on the previous level
      if (first_ff) begin
         ml_nx = rd_a_data;
         mr_nx = rd_b_data;
      end else begin
         ml_nx = (fl_ff && (rd_a_data < cur_ff)) ? rd_a_data : cur_ff;
         mr_nx = (fr_ff && (rd_b_data < mr_ff)) ? rd_b_data : mr_ff;
      end
      span = rnode_ff - node_ff;

      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      rnode_in      = rnode_ff;
      cur_in        = cur_ff;
      mr_in         = mr_ff;
      fl_in         = fl_ff;
      fr_in         = fr_ff;
      first_in      = first_ff;
      rsp_strobe_in = 1'b0;
      rsp_min_in    = rsp_min_ff;
      wr.en         = 1'b0;
      wr.addr       = node_ff;
      wr.data       = cur_ff;
      rd_a_addr     = node_ff;
      rd_b_addr     = rnode_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff;
            wr.data = rmst_pkg::EMPTY_VAL;
            clr_in  = clr_ff + NODE_ONE;
            if (clr_ff == NODE_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_command == rmst_pkg::CMD_WRITE) begin
                  node_in  = {1'b1, req_lo};
                  cur_in   = req_value;
                  state_in = S_WLEAF;
               end else begin
                  node_in  = (req_lo > req_hi) ? {1'b1, req_hi} : {1'b1, req_lo};
                  rnode_in = (req_lo > req_hi) ? {1'b1, req_lo} : {1'b1, req_hi};
                  state_in = S_QSTART;
               end
            end
         end
         S_WLEAF: begin
            wr.en     = 1'b1;
            wr.addr   = node_ff;
            wr.data   = cur_ff;
            rd_a_addr = node_ff ^ NODE_ONE;
            node_in   = node_ff >> 1;
            state_in  = S_WUP;
         end
         S_WUP: begin
            // sibling of the node below arrives now; write the parent
            wr.en     = 1'b1;
            wr.addr   = node_ff;
            wr.data   = par_val;
            cur_in    = par_val;
            rd_a_addr = node_ff ^ NODE_ONE;
            node_in   = node_ff >> 1;
            if (node_ff == NODE_ONE) begin
               state_in = S_IDLE;
            end
         end
         S_QSTART: begin
            rd_a_addr = node_ff;
            rd_b_addr = rnode_ff;
            first_in  = 1'b1;
            state_in  = S_QWALK;
         end
         S_QWALK: begin
            cur_in   = ml_nx;
            mr_in    = mr_nx;
            first_in = 1'b0;
            if (span > NODE_ONE) begin
               rd_a_addr = node_ff + NODE_ONE;
               rd_b_addr = rnode_ff - NODE_ONE;
               fl_in     = ~node_ff[0];
               fr_in     = rnode_ff[0];
               node_in   = node_ff >> 1;
               rnode_in  = rnode_ff >> 1;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_min_in    = (mr_nx < ml_nx) ? mr_nx : ml_nx;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      rnode_ff   <= rnode_in;
      cur_ff     <= cur_in;
      mr_ff      <= mr_in;
      fl_ff      <= fl_in;
      fr_ff      <= fr_in;
      first_ff   <= first_in;
      rsp_min_ff <= rsp_min_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_minimum = rsp_min_ff;

endmodule

FILE: bench/testbench.sv
module testbench;

   localparam int PERIOD       = 8;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 40;
   localparam int RANDOM_ITEMS = 1250;

   typedef logic [rmst_pkg::IDX_W-1:0] idx_type;

   class min_tree_scoreboard;
      rmst_pkg::value_type node_min[rmst_pkg::DEPTH];
      rmst_pkg::value_type pending_minimum[$];
      int errors;
      int checked;
      int writes;
      int queries;

      function new();
         foreach (node_min[k]) node_min[k] = rmst_pkg::EMPTY_VAL;
         errors  = 0;
         checked = 0;
         writes  = 0;
         queries = 0;
      endfunction

      function rmst_pkg::value_type lesser(rmst_pkg::value_type a, rmst_pkg::value_type b);
         return (a < b) ? a : b;
      endfunction

      // Apply one accepted item to the tree copy; a query queues its minimum.
      function void note_item(logic cmd, idx_type lo, idx_type hi,
                              rmst_pkg::value_type val);
         logic [rmst_pkg::LEAF_W-1:0] lo_leaf;
         logic [rmst_pkg::LEAF_W-1:0] hi_leaf;
         logic [rmst_pkg::LEAF_W-1:0] swap;
         rmst_pkg::node_type          l;
         rmst_pkg::node_type          r;
         rmst_pkg::value_type         ml;
         rmst_pkg::value_type         mr;
         lo_leaf = lo[rmst_pkg::LEAF_W-1:0];
         hi_leaf = hi[rmst_pkg::LEAF_W-1:0];
         if (cmd == rmst_pkg::CMD_WRITE) begin
            writes++;
            l = rmst_pkg::node_type'(rmst_pkg::LEAVES) + rmst_pkg::node_type'(lo_leaf);
            node_min[l] = val;
            for (l = l >> 1; l != 0; l = l >> 1)
               node_min[l] = lesser(node_min[2 * l], node_min[2 * l + 1]);
         end else begin
            queries++;
            if (lo_leaf > hi_leaf) begin
               swap    = lo_leaf;
               lo_leaf = hi_leaf;
               hi_leaf = swap;
            end
            l  = rmst_pkg::node_type'(rmst_pkg::LEAVES) + rmst_pkg::node_type'(lo_leaf);
            r  = rmst_pkg::node_type'(rmst_pkg::LEAVES) + rmst_pkg::node_type'(hi_leaf);
            ml = node_min[l];
            mr = node_min[r];
            // climb while the boundaries are neither equal nor adjacent
            while (r - l > 1) begin
               if (!l[0]) ml = lesser(ml, node_min[l + 1]);
               if (r[0])  mr = lesser(mr, node_min[r - 1]);
               l = l >> 1;
               r = r >> 1;
            end
            pending_minimum = {pending_minimum, lesser(ml, mr)};
         end
      endfunction

      function void check_minimum(rmst_pkg::value_type actual);
         rmst_pkg::value_type expected;
         if (pending_minimum.size() == 0) begin
            errors++;
            $display("%0t: unexpected minimum: expected none, actual %h", $time, actual);
            return;
         end
         expected = pending_minimum.pop_front();
         checked++;
         if (actual !== expected) begin
            errors++;
            $display("%0t: minimum mismatch: expected %h, actual %h", $time, expected, actual);
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_command;
   idx_type                       req_leaf_index;
   idx_type                       req_range_high;
   logic [rmst_pkg::VAL_W-1:0]    req_value;
   logic                          rsp_strobe;
   logic [rmst_pkg::VAL_W-1:0]    rsp_minimum;

   min_tree_scoreboard  sb;
   int                  cycle_count;

   range_min_segment_tree dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_leaf_index (req_leaf_index),
      .req_range_high (req_range_high),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_minimum    (rsp_minimum)
   );

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = rmst_pkg::CMD_WRITE;
      req_leaf_index = '0;
      req_range_high = '0;
      req_value      = '0;
      sb             = new();
      cycle_count    = 0;
   end

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d minima outstanding", $time,
                  sb.pending_minimum.size());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_minimum(rsp_minimum);
         if (start && !busy)
            sb.note_item(req_command, req_leaf_index, req_range_high, req_value);
      end
   end

   // Hold the item on the ports until an edge with busy low takes it.
   task automatic send_item(input logic cmd, input idx_type lo,
                            input idx_type hi, input rmst_pkg::value_type val);
      @(negedge clock);
      start          = 1'b1;
      req_command    = cmd;
      req_leaf_index = lo;
      req_range_high = hi;
      req_value      = val;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start          = 1'b0;
         req_command    = 1'($urandom_range(0, 1));
         req_leaf_index = idx_type'($urandom);
         req_range_high = idx_type'($urandom);
         req_value      = rmst_pkg::value_type'($urandom);
      end
   endtask

   task automatic drain_minima();
      hold_off(1);
      while (sb.pending_minimum.size() != 0) @(posedge clock);
      hold_off(SETTLE);
   endtask

   function automatic rmst_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return rmst_pkg::EMPTY_VAL;
         2:       return rmst_pkg::EMPTY_VAL - rmst_pkg::value_type'(1);
         3, 4:    return rmst_pkg::value_type'($urandom_range(0, 255));
         default: return rmst_pkg::value_type'($urandom);
      endcase
   endfunction

   task automatic send_random_item();
      idx_type lo;
      idx_type hi;
      lo = idx_type'($urandom);
      hi = idx_type'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         // bias writes toward the edges now and then
         if ($urandom_range(0, 7) == 0) lo = $urandom_range(0, 1) ? '0 : '1;
         send_item(rmst_pkg::CMD_WRITE, lo, hi, pick_value());
      end else begin
         case ($urandom_range(0, 7))
            0:       hi = lo;
            1:       begin lo = '0; hi = '1; end
            2, 3:    hi = (lo > idx_type'(1007)) ? lo - idx_type'($urandom_range(0, 15))
                                                 : lo + idx_type'($urandom_range(0, 15));
            default: ;
         endcase
         if ($urandom_range(0, 1))
            send_item(rmst_pkg::CMD_QUERY, lo, hi, rmst_pkg::value_type'($urandom));
         else
            send_item(rmst_pkg::CMD_QUERY, hi, lo, rmst_pkg::value_type'($urandom));
      end
   endtask

   task automatic run_phase(input int items, input int idle_pct);
      repeat (items) begin
         if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 6));
         send_random_item();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tree, boundary leaves, extreme values, reversed ranges
      send_item(rmst_pkg::CMD_QUERY, 10'd0,    10'd1023, rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_WRITE, 10'd0,    10'd1023, '0);
      send_item(rmst_pkg::CMD_WRITE, 10'd1023, 10'd0,
                rmst_pkg::EMPTY_VAL - rmst_pkg::value_type'(1));
      send_item(rmst_pkg::CMD_WRITE, 10'd512,  10'd5,    rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_WRITE, 10'd511,  10'd0,    rmst_pkg::value_type'(5));
      send_item(rmst_pkg::CMD_QUERY, 10'd0,    10'd0,    '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd1023, 10'd1023, rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_QUERY, 10'd1023, 10'd0,    '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd1,    10'd1022, rmst_pkg::value_type'(17));
      send_item(rmst_pkg::CMD_QUERY, 10'd512,  10'd1023, '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd513,  10'd1022, '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd1000, 10'd3,    '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd510,  10'd511,  '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd511,  10'd512,  '0);
      send_item(rmst_pkg::CMD_WRITE, 10'd2,    10'd3,    rmst_pkg::value_type'(3));
      send_item(rmst_pkg::CMD_WRITE, 10'd3,    10'd2,    rmst_pkg::value_type'(2));
      send_item(rmst_pkg::CMD_QUERY, 10'd2,    10'd3,    '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd3,    10'd2,    rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_WRITE, 10'd0,    10'd1023, rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_QUERY, 10'd0,    10'd1,    '0);
      send_item(rmst_pkg::CMD_QUERY, 10'd0,    10'd511,  '0);
      send_item(rmst_pkg::CMD_WRITE, 10'd511,  10'd0,    rmst_pkg::EMPTY_VAL);
      send_item(rmst_pkg::CMD_QUERY, 10'd1023, 10'd0,    '0);
      drain_minima();

      run_phase(RANDOM_ITEMS / 3, 9);
      drain_minima();
      run_phase(RANDOM_ITEMS / 3, 68);
      drain_minima();
      run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
      drain_minima();

      $display("Run covered %0d writes and %0d range queries; %0d minima compared.",
               sb.writes, sb.queries, sb.checked);
      $display("Pacing went from light to heavy sender gaps, then back-to-back items.");
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAILURE");
      end
      $finish;
   end
endmodule
